// ===== design/pt2d_pkg.sv =====
// pt2d_pkg: shared types, codes and constants of the 2d point transform
// depends on nothing; used by pt2d_cordic, pt2d_datapath and point_2d_transform

package pt2d_pkg;

	// default geometry
	localparam int COORD_WIDTH   = 24;
	localparam int CORDIC_STAGES = 16;

	// angle format: degrees q9.7, cordic angle in degrees q.16
	localparam int HALF_TURN           = 180;
	localparam int ANGLE_UNITS_PER_DEG = 128;
	localparam int ATAN_ENTRIES        = 24;
	localparam int ANGLE_WIDTH         = 17;
	localparam int FACTOR_WIDTH        = 16;

	// cordic gain compensation, q.30
	localparam longint CORDIC_GAIN_Q30 = 652032874;

	// operation codes
	typedef logic [1:0] op_t;
	localparam op_t OP_TRANSLATE = 2'd0;
	localparam op_t OP_SCALE     = 2'd1;
	localparam op_t OP_ROTATE    = 2'd2;

	// register indexes
	localparam int CFG_IDX_WIDTH = 3;
	typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_OFFSET_X = 3'd0;
	localparam cfg_idx_t REG_OFFSET_Y = 3'd1;
	localparam cfg_idx_t REG_FACTOR_X = 3'd2;
	localparam cfg_idx_t REG_FACTOR_Y = 3'd3;
	localparam cfg_idx_t REG_TURN     = 3'd4;

	// control that travels down the pipeline with each word
	typedef struct packed {
		logic valid;
		op_t  op;
	} pipe_ctl_t;

	// arctangent of 2^-i in degrees q.16
	function automatic logic [25:0] atan_deg(input logic [4:0] idx);
		logic [25:0] v;
		case (idx)
			5'd0:    v = 26'd2949120;
			5'd1:    v = 26'd1740967;
			5'd2:    v = 26'd919879;
			5'd3:    v = 26'd466945;
			5'd4:    v = 26'd234379;
			5'd5:    v = 26'd117304;
			5'd6:    v = 26'd58666;
			5'd7:    v = 26'd29335;
			5'd8:    v = 26'd14668;
			5'd9:    v = 26'd7334;
			5'd10:   v = 26'd3667;
			5'd11:   v = 26'd1833;
			5'd12:   v = 26'd917;
			5'd13:   v = 26'd458;
			5'd14:   v = 26'd229;
			5'd15:   v = 26'd115;
			5'd16:   v = 26'd57;
			5'd17:   v = 26'd29;
			5'd18:   v = 26'd14;
			5'd19:   v = 26'd7;
			5'd20:   v = 26'd4;
			5'd21:   v = 26'd2;
			5'd22:   v = 26'd1;
			default: v = 26'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/point_2d_transform.sv =====
// point_2d_transform: top level, 2d translate / scale / rotate of one point per word
// depends on pt2d_pkg, pt2d_cordic and pt2d_datapath
// done pulses once the word has passed the 4 pipeline stages and the output reg
// throughput: one word per cycle while busy is low; the receiver cannot stall
// reset: registers return to offset 0, factor 1.0, angle 0; busy stays high after
// reset and after each angle write while cos/sin are rebuilt

module point_2d_transform #(
	parameter int COORD_WIDTH   = pt2d_pkg::COORD_WIDTH,
	parameter int CORDIC_STAGES = pt2d_pkg::CORDIC_STAGES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// point channel
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            operation,
	input  logic signed [COORD_WIDTH-1:0]         point_x,
	input  logic signed [COORD_WIDTH-1:0]         point_y,
	// result channel
	output logic                                  done,
	output logic signed [COORD_WIDTH-1:0]         result_x,
	output logic signed [COORD_WIDTH-1:0]         result_y,
	output logic                                  saturated,
	// register write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pt2d_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [CFG_DW-1:0]                     cfg_data
);

	localparam int TRIG_FRAC = ((62 - COORD_WIDTH) < 30) ? (62 - COORD_WIDTH) : 30;
	// data word is wide enough for the widest register
	localparam int CFG_DW = (COORD_WIDTH > pt2d_pkg::ANGLE_WIDTH) ?
		COORD_WIDTH : pt2d_pkg::ANGLE_WIDTH;

	// configuration registers
	logic signed [COORD_WIDTH-1:0]              offset_x_q, offset_y_q;
	logic [pt2d_pkg::FACTOR_WIDTH-1:0]          factor_x_q, factor_y_q;
	logic signed [pt2d_pkg::ANGLE_WIDTH-1:0]    turn_q;

	logic                                       cfg_write;
	logic                                       turn_write;
	logic                                       trig_busy;
	logic                                       accept;
	logic signed [TRIG_FRAC+1:0]                cos_val, sin_val;

	// register writes are never held off
	assign cfg_ready  = 1'b1;
	assign cfg_write  = cfg_valid & cfg_ready;
	assign turn_write = cfg_write & (cfg_index == pt2d_pkg::REG_TURN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			factor_x_q <= pt2d_pkg::FACTOR_WIDTH'(256);
			factor_y_q <= pt2d_pkg::FACTOR_WIDTH'(256);
			turn_q     <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pt2d_pkg::REG_OFFSET_X: offset_x_q <= cfg_data[COORD_WIDTH-1:0];
				pt2d_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data[COORD_WIDTH-1:0];
				pt2d_pkg::REG_FACTOR_X: factor_x_q <= cfg_data[pt2d_pkg::FACTOR_WIDTH-1:0];
				pt2d_pkg::REG_FACTOR_Y: factor_y_q <= cfg_data[pt2d_pkg::FACTOR_WIDTH-1:0];
				pt2d_pkg::REG_TURN:     turn_q     <= cfg_data[pt2d_pkg::ANGLE_WIDTH-1:0];
				default: begin
					// unknown index: write is dropped
				end
			endcase
		end
	end

	// cos and sin of the angle are rebuilt once per angle write, not per point;
	// the point pipeline waits on busy only while that is running
	pt2d_cordic #(
		.COORD_WIDTH   (COORD_WIDTH),
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (turn_write),
		.turn    (turn_q),
		.busy    (trig_busy),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	assign busy   = trig_busy;
	assign accept = start & ~trig_busy;

	// point pipeline: a new word may enter every cycle while busy is low
	pt2d_datapath #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_op     (operation),
		.in_x      (point_x),
		.in_y      (point_y),
		.offset_x  (offset_x_q),
		.offset_y  (offset_y_q),
		.factor_x  (factor_x_q),
		.factor_y  (factor_y_q),
		.cos_val   (cos_val),
		.sin_val   (sin_val),
		.out_valid (done),
		.out_x     (result_x),
		.out_y     (result_y),
		.out_sat   (saturated)
	);

endmodule

// ===== design/pt2d_cordic.sv =====
// pt2d_cordic: iterative cordic that turns the rotation angle into cos and sin
// depends on pt2d_pkg (atan table, gain, angle constants)

module pt2d_cordic #(
	parameter int COORD_WIDTH   = pt2d_pkg::COORD_WIDTH,
	parameter int CORDIC_STAGES = pt2d_pkg::CORDIC_STAGES
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       restart,
	input  logic signed [pt2d_pkg::ANGLE_WIDTH-1:0]    turn,
	output logic                                       busy,
	output logic signed [TRIG_FRAC+1:0]                cos_val,
	output logic signed [TRIG_FRAC+1:0]                sin_val
);

	localparam int TRIG_FRAC = ((62 - COORD_WIDTH) < 30) ? (62 - COORD_WIDTH) : 30;
	localparam int RS        = 30 - TRIG_FRAC;
	localparam int XW        = 34;
	localparam int ZW        = 26;
	localparam int AW        = 18;
	localparam int CNTW      = $clog2(CORDIC_STAGES);

	localparam logic signed [AW-1:0] HALF_A =
		AW'(pt2d_pkg::HALF_TURN * pt2d_pkg::ANGLE_UNITS_PER_DEG);
	localparam logic signed [AW-1:0] FULL_A = AW'(2 * pt2d_pkg::HALF_TURN *
		pt2d_pkg::ANGLE_UNITS_PER_DEG);
	localparam logic signed [AW-1:0] QUARTER_A =
		AW'(pt2d_pkg::HALF_TURN * pt2d_pkg::ANGLE_UNITS_PER_DEG / 2);
	localparam int ZSHIFT = $clog2(65536 / pt2d_pkg::ANGLE_UNITS_PER_DEG);
	localparam logic signed [XW-1:0] GAIN   = XW'(pt2d_pkg::CORDIC_GAIN_Q30);
	localparam logic signed [XW-1:0] HALF_R = (XW'(1) << RS) >>> 1;
	localparam logic [CNTW-1:0] LAST_STAGE  = CNTW'(CORDIC_STAGES - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOAD   = 2'd1;
	localparam logic [1:0] ST_RUN    = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]             state_q;
	logic [CNTW-1:0]        cnt_q;
	logic signed [XW-1:0]   x_q, y_q;
	logic signed [ZW-1:0]   z_q;
	logic                   flip_q;

	logic signed [AW-1:0]   a0, a1, a2;
	logic                   flip_d;
	logic signed [XW-1:0]   dx, dy, xr, yr, xn, yn;
	logic signed [ZW-1:0]   atan_v;

	// fold the angle into [-90, 90] degrees
	always_comb begin
		a0 = AW'(turn);
		if (a0 >= HALF_A) begin
			a1 = a0 - FULL_A;
		end else if (a0 < -HALF_A) begin
			a1 = a0 + FULL_A;
		end else begin
			a1 = a0;
		end
		flip_d = 1'b0;
		if (a1 > QUARTER_A) begin
			a2     = a1 - HALF_A;
			flip_d = 1'b1;
		end else if (a1 < -QUARTER_A) begin
			a2     = a1 + HALF_A;
			flip_d = 1'b1;
		end else begin
			a2 = a1;
		end
	end

	assign dx     = y_q >>> cnt_q;
	assign dy     = x_q >>> cnt_q;
	assign atan_v = ZW'(pt2d_pkg::atan_deg(5'(cnt_q)));

	// round q.30 down to the trig precision
	assign xr = (x_q + HALF_R) >>> RS;
	assign yr = (y_q + HALF_R) >>> RS;
	assign xn = flip_q ? -xr : xr;
	assign yn = flip_q ? -yr : yr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else if (restart) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					state_q <= ST_RUN;
					cnt_q   <= '0;
				end
				ST_RUN: begin
					if (cnt_q == LAST_STAGE) begin
						state_q <= ST_FINISH;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				x_q    <= GAIN;
				y_q    <= '0;
				z_q    <= ZW'(a2) <<< ZSHIFT;
				flip_q <= flip_d;
			end
			ST_RUN: begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_v;
				end
			end
			ST_FINISH: begin
				cos_val <= xn[TRIG_FRAC+1:0];
				sin_val <= yn[TRIG_FRAC+1:0];
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== design/pt2d_datapath.sv =====
// pt2d_datapath: 4 stages (capture, multiply, combine, round), clamped output
// depends on pt2d_pkg (operation codes, pipeline control struct)

module pt2d_datapath #(
	parameter int COORD_WIDTH = pt2d_pkg::COORD_WIDTH
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	input  pt2d_pkg::op_t                              in_op,
	input  logic signed [COORD_WIDTH-1:0]              in_x,
	input  logic signed [COORD_WIDTH-1:0]              in_y,
	input  logic signed [COORD_WIDTH-1:0]              offset_x,
	input  logic signed [COORD_WIDTH-1:0]              offset_y,
	input  logic [pt2d_pkg::FACTOR_WIDTH-1:0]          factor_x,
	input  logic [pt2d_pkg::FACTOR_WIDTH-1:0]          factor_y,
	input  logic signed [TRIG_FRAC+1:0]                cos_val,
	input  logic signed [TRIG_FRAC+1:0]                sin_val,
	output logic                                       out_valid,
	output logic signed [COORD_WIDTH-1:0]              out_x,
	output logic signed [COORD_WIDTH-1:0]              out_y,
	output logic                                       out_sat
);

	localparam int TRIG_FRAC = ((62 - COORD_WIDTH) < 30) ? (62 - COORD_WIDTH) : 30;
	localparam int MW = ((TRIG_FRAC + 2) > (pt2d_pkg::FACTOR_WIDTH + 1)) ?
		(TRIG_FRAC + 2) : (pt2d_pkg::FACTOR_WIDTH + 1);
	localparam int PRW = COORD_WIDTH + MW;
	localparam int PW  = PRW + 1;
	localparam int TW  = COORD_WIDTH + 1;
	localparam int SCALE_SHIFT = 8;

	localparam logic signed [PW-1:0] HALF_ROT   = (PW'(1) << TRIG_FRAC) >>> 1;
	localparam logic signed [PW-1:0] HALF_SCALE = (PW'(1) << SCALE_SHIFT) >>> 1;
	localparam logic signed [PW-1:0] MAX_C = PW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam logic signed [PW-1:0] MIN_C = -MAX_C - PW'(1);

	pt2d_pkg::pipe_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	logic signed [COORD_WIDTH-1:0] x_s1, y_s1;
	logic signed [MW-1:0]          coef_a, coef_d, coef_s;
	logic signed [PRW-1:0]         pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [TW-1:0]          tx_s2, ty_s2, tx_d, ty_d;
	logic signed [PW-1:0]          sx_s3, sy_s3, sx_d, sy_d;
	logic signed [PW-1:0]          rx_s4, ry_s4, rx_d, ry_d;
	logic                          hi_x, lo_x, hi_y, lo_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			ctl_s4    <= '0;
			out_valid <= 1'b0;
		end else begin
			ctl_s1    <= '{valid: in_valid, op: in_op};
			ctl_s2    <= ctl_s1;
			ctl_s3    <= ctl_s2;
			ctl_s4    <= ctl_s3;
			out_valid <= ctl_s4.valid;
		end
	end

	// stage 1: capture the point
	always_ff @(posedge clk) begin
		x_s1 <= in_x;
		y_s1 <= in_y;
	end

	// stage 2: products and the translate sum
	always_comb begin
		coef_s = MW'(sin_val);
		if (ctl_s1.op == pt2d_pkg::OP_ROTATE) begin
			coef_a = MW'(cos_val);
			coef_d = MW'(cos_val);
		end else begin
			coef_a = MW'(factor_x);
			coef_d = MW'(factor_y);
		end
		if (ctl_s1.op == pt2d_pkg::OP_TRANSLATE) begin
			tx_d = TW'(x_s1) + TW'(offset_x);
			ty_d = TW'(y_s1) + TW'(offset_y);
		end else begin
			tx_d = TW'(x_s1);
			ty_d = TW'(y_s1);
		end
	end

	always_ff @(posedge clk) begin
		pa_s2 <= x_s1 * coef_a;
		pb_s2 <= y_s1 * coef_s;
		pc_s2 <= x_s1 * coef_s;
		pd_s2 <= y_s1 * coef_d;
		tx_s2 <= tx_d;
		ty_s2 <= ty_d;
	end

	// stage 3: combine the products
	always_comb begin
		case (ctl_s2.op)
			pt2d_pkg::OP_ROTATE: begin
				sx_d = PW'(pa_s2) - PW'(pb_s2);
				sy_d = PW'(pc_s2) + PW'(pd_s2);
			end
			pt2d_pkg::OP_SCALE: begin
				sx_d = PW'(pa_s2);
				sy_d = PW'(pd_s2);
			end
			default: begin
				sx_d = PW'(tx_s2);
				sy_d = PW'(ty_s2);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sx_s3 <= sx_d;
		sy_s3 <= sy_d;
	end

	// stage 4: round scale (q8.8) and rotate products half up to whole units
	always_comb begin
		case (ctl_s3.op)
			pt2d_pkg::OP_ROTATE: begin
				rx_d = (sx_s3 + HALF_ROT) >>> TRIG_FRAC;
				ry_d = (sy_s3 + HALF_ROT) >>> TRIG_FRAC;
			end
			pt2d_pkg::OP_SCALE: begin
				rx_d = (sx_s3 + HALF_SCALE) >>> SCALE_SHIFT;
				ry_d = (sy_s3 + HALF_SCALE) >>> SCALE_SHIFT;
			end
			default: begin
				rx_d = sx_s3;
				ry_d = sy_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rx_s4 <= rx_d;
		ry_s4 <= ry_d;
	end

	// output register: clamp to the coordinate range
	assign hi_x = (rx_s4 > MAX_C);
	assign lo_x = (rx_s4 < MIN_C);
	assign hi_y = (ry_s4 > MAX_C);
	assign lo_y = (ry_s4 < MIN_C);

	always_ff @(posedge clk) begin
		out_x   <= hi_x ? MAX_C[COORD_WIDTH-1:0] :
			lo_x ? MIN_C[COORD_WIDTH-1:0] : rx_s4[COORD_WIDTH-1:0];
		out_y   <= hi_y ? MAX_C[COORD_WIDTH-1:0] :
			lo_y ? MIN_C[COORD_WIDTH-1:0] : ry_s4[COORD_WIDTH-1:0];
		out_sat <= hi_x | lo_x | hi_y | lo_y;
	end

endmodule
